>>> sv/prag_pkg.sv
// prag_pkg: shared widths, constants, register indexes and divider interface types
// for the partition ready aggregator. No dependencies.
package prag_pkg;

	localparam int unsigned USER_W      = 11;  // user_parts register
	localparam int unsigned NET_W       = 7;   // net_parts register, walk index
	localparam int unsigned ID_W        = 10;  // user_index
	localparam int unsigned OUT_NET_W   = 6;   // net_index result field
	localparam int unsigned COUNT_W     = 11;  // ready count
	localparam int unsigned START_W     = NET_W + ID_W;
	localparam int unsigned DIV_W       = 11;
	localparam int unsigned DIV_CNT_W   = $clog2(DIV_W + 1);
	localparam int unsigned CFG_IDX_W   = 1;
	localparam int unsigned CFG_DATA_W  = 11;

	localparam int unsigned MAX_NET_PARTS_DEF = 64;

	localparam logic [USER_W-1:0]    MAX_USER_PARTS = 11'd1024;
	localparam logic [COUNT_W-1:0]   COUNT_MAX      = 11'h7ff;

	localparam logic [CFG_IDX_W-1:0] REG_USER_PARTS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_NET_PARTS  = 1'b1;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

>>> sv/prag_ram.sv
// prag_ram: generic single-write, single-read synchronous RAM with registered read.
// Stand-alone; no package dependencies.
module prag_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/prag_div.sv
// prag_div: restoring divider, one quotient bit per cycle, for the partition mapping.
// Depends on prag_pkg for widths and the request/response structs.
module prag_div (
	input  logic               clk,
	input  logic               arst_n,
	input  prag_pkg::div_req_t req,
	output prag_pkg::div_rsp_t rsp
);
	import prag_pkg::*;

	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_W-1:0]     dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_W:0]       trial;
	logic [DIV_W:0]       diff;
	logic                 take;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign take  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], take};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

>>> sv/partition_ready_aggregator.sv
// Partition ready aggregator top level: configuration registers, sequencer, count memory.
// Depends on prag_pkg, prag_div and prag_ram.
//
// Each accepted word names a ready user partition; the block maps it onto one or more
// network partitions, bumps each one's saturating ready count in the count memory and
// emits one result word per network partition, with fire set when a count just reaches
// its threshold and last on the final word. Unmappable words give a single error word.
// After reset the count memory is swept to zero, one entry a cycle, during which
// item_stall stays high. An item rejected by the configuration or index check goes
// straight to an error word. Otherwise, when user_parts <= net_parts, one division gives
// the step and a multiply the start; else one division gives the threshold and a second
// one the start. After the range check each network partition walked has its count read,
// then written, through the single-read-port memory, and the result side may stall each
// word. One item is in flight at a time; the next is taken while its last result word
// still waits.
module partition_ready_aggregator #(
	parameter int unsigned MAX_NET_PARTS = prag_pkg::MAX_NET_PARTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [prag_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [prag_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [prag_pkg::ID_W-1:0]           user_index,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [prag_pkg::OUT_NET_W-1:0]      net_index,
	output logic                                fire,
	output logic                                error,
	output logic                                last
);
	import prag_pkg::*;

	localparam int unsigned AW = (MAX_NET_PARTS > 1) ? $clog2(MAX_NET_PARTS) : 1;

	typedef enum logic [8:0] {
		S_CLR  = 9'b000000001,
		S_IDLE = 9'b000000010,
		S_DIV1 = 9'b000000100,
		S_DIV2 = 9'b000001000,
		S_MUL  = 9'b000010000,
		S_CHK  = 9'b000100000,
		S_RD   = 9'b001000000,
		S_WR   = 9'b010000000,
		S_ERR  = 9'b100000000
	} state_t;

	state_t              state_q, state_d;
	logic [USER_W-1:0]   user_parts_q;
	logic [NET_W-1:0]    net_parts_q;
	logic [AW-1:0]       clr_q;
	logic [ID_W-1:0]     id_q;
	logic                small_q;
	logic [NET_W-1:0]    step_q;
	logic [COUNT_W-1:0]  thr_q;
	logic [START_W-1:0]  start_q;
	logic [NET_W-1:0]    idx_q;
	logic [NET_W-1:0]    end_q;

	logic                out_valid_q;
	logic [OUT_NET_W-1:0] out_net_q;
	logic                out_fire_q;
	logic                out_err_q;
	logic                out_last_q;

	div_req_t            div_req;
	div_rsp_t            div_rsp;

	logic                item_take;
	logic                slot_free;
	logic                cfg_bad;
	logic                id_bad;
	logic                small_map;
	logic [START_W:0]    end_w;
	logic                range_bad;
	logic                walk_last;
	logic [COUNT_W-1:0]  count_old;
	logic [COUNT_W-1:0]  count_new;
	logic                count_sat;
	logic                ram_we;
	logic                ram_re;
	logic [AW-1:0]       ram_waddr;
	logic [COUNT_W-1:0]  ram_wdata;
	logic                load_word;
	logic                load_err;

	assign cfg_ready  = 1'b1;
	assign item_stall = (state_q != S_IDLE);
	assign item_take  = item_valid && !item_stall;
	assign slot_free  = !out_valid_q || !result_stall;

	assign cfg_bad   = (user_parts_q == '0) || (user_parts_q > MAX_USER_PARTS) ||
	                   (net_parts_q == '0) || (32'(net_parts_q) > 32'(MAX_NET_PARTS));
	assign id_bad    = {1'b0, user_index} >= user_parts_q;
	assign small_map = user_parts_q <= USER_W'(net_parts_q);

	assign end_w     = {1'b0, start_q} + (START_W + 1)'(step_q);
	assign range_bad = (start_q >= START_W'(net_parts_q)) ||
	                   (end_w > (START_W + 1)'(net_parts_q));
	assign walk_last = ({1'b0, idx_q} + 1'b1) == {1'b0, end_q};

	assign count_sat = (count_old == COUNT_MAX);
	assign count_new = count_old + 1'b1;
	assign load_word = (state_q == S_WR) && slot_free;
	assign load_err  = (state_q == S_ERR) && slot_free;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_parts_q <= USER_W'(1);
			net_parts_q  <= NET_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_USER_PARTS: user_parts_q <= cfg_data[USER_W-1:0];
				REG_NET_PARTS:  net_parts_q  <= cfg_data[NET_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		div_req = '0;
		if (item_take && !cfg_bad && !id_bad) begin
			div_req.start = 1'b1;
			if (small_map) begin
				div_req.dividend = USER_W'(net_parts_q);
				div_req.divisor  = user_parts_q;
			end else begin
				div_req.dividend = user_parts_q;
				div_req.divisor  = USER_W'(net_parts_q);
			end
		end else if ((state_q == S_DIV1) && div_rsp.done && !small_q) begin
			div_req.start    = 1'b1;
			div_req.dividend = DIV_W'(id_q);
			div_req.divisor  = div_rsp.quotient;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLR: begin
				if (clr_q == AW'(MAX_NET_PARTS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (item_take) begin
					state_d = (cfg_bad || id_bad) ? S_ERR : S_DIV1;
				end
			end
			S_DIV1: begin
				if (div_rsp.done) begin
					state_d = small_q ? S_MUL : S_DIV2;
				end
			end
			S_DIV2: begin
				if (div_rsp.done) begin
					state_d = S_CHK;
				end
			end
			S_MUL:  state_d = S_CHK;
			S_CHK:  state_d = range_bad ? S_ERR : S_RD;
			S_RD:   state_d = S_WR;
			S_WR: begin
				if (slot_free) begin
					state_d = walk_last ? S_IDLE : S_RD;
				end
			end
			S_ERR: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (load_word || load_err) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		if (item_take) begin
			id_q    <= user_index;
			small_q <= small_map;
		end
		if ((state_q == S_DIV1) && div_rsp.done) begin
			if (small_q) begin
				step_q <= div_rsp.quotient[NET_W-1:0];
				thr_q  <= COUNT_W'(1);
			end else begin
				step_q <= NET_W'(1);
				thr_q  <= div_rsp.quotient;
			end
		end
		if ((state_q == S_DIV2) && div_rsp.done) begin
			start_q <= START_W'(div_rsp.quotient);
		end
		if (state_q == S_MUL) begin
			start_q <= step_q * id_q;
		end
		if (state_q == S_CHK) begin
			idx_q <= start_q[NET_W-1:0];
			end_q <= end_w[NET_W-1:0];
		end
		if (load_word) begin
			idx_q      <= idx_q + 1'b1;
			out_net_q  <= idx_q[OUT_NET_W-1:0];
			out_fire_q <= !count_sat && (count_new == thr_q);
			out_err_q  <= 1'b0;
			out_last_q <= walk_last;
		end else if (load_err) begin
			out_net_q  <= '0;
			out_fire_q <= 1'b0;
			out_err_q  <= 1'b1;
			out_last_q <= 1'b1;
		end
	end

	assign ram_re    = (state_q == S_RD);
	assign ram_we    = (state_q == S_CLR) || (load_word && !count_sat);
	assign ram_waddr = (state_q == S_CLR) ? clr_q : AW'(idx_q);
	assign ram_wdata = (state_q == S_CLR) ? '0 : count_new;

	prag_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	prag_ram #(
		.WIDTH (COUNT_W),
		.DEPTH (MAX_NET_PARTS)
	) u_count_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (AW'(idx_q)),
		.rdata (count_old)
	);

	assign result_valid = out_valid_q;
	assign net_index    = out_net_q;
	assign fire         = out_fire_q;
	assign error        = out_err_q;
	assign last         = out_last_q;

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("second word taken while an item is in flight");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && error |-> last && !fire)
		else $error("error word without last or with fire");

	a_ram_ports: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_re && ram_we))
		else $error("count memory read and written in one cycle");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIV1) || (state_q == S_DIV2))
		else $error("divider result with no division pending");

endmodule
